// ----- rtl/core/spq_pkg.sv -----
// Shared types and constants for the sorted priority queue.
`default_nettype none
package spq_pkg;

  localparam int CAPACITY = 16;
  localparam int CNT_W    = $clog2(CAPACITY + 1);
  localparam int ID_W     = 16;
  localparam int PRI_W    = 8;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_POP    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NONE   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_EMPTY     = 2'd1,
    ST_NOT_FOUND = 2'd2,
    ST_FULL      = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    ACT_HOLD,
    ACT_INSERT,
    ACT_REMOVE
  } act_t;

  typedef struct packed {
    logic             valid;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } entry_t;

  typedef struct packed {
    act_t             act;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
  } cmd_t;

endpackage
`default_nettype wire

// ----- rtl/core/sorted_priority_queue.sv -----
// Sorted priority queue: a chain of entry cells with a registered result.
//
// Input channel: in_valid/in_ready carry operation, task_id and
// priority_req. Operation insert places the entry after every entry of
// equal or higher priority, pop removes the head, delete removes the first
// entry whose identifier matches. Operation code 3 changes nothing.
// Output channel: out_valid/out_ready carry status, removed_id,
// removed_priority and entry_count, one result per accepted item.
//
// Every cell compares its entry with the request in the same cycle and
// takes its next value from itself, its left or right neighbor, or the new
// entry. The first matching cell for a delete comes from a log-depth prefix
// OR over the cells' match flags. One item is taken per cycle unless a
// held result stalls the input; each result is registered at the transfer.
//
// Reset empties the queue and clears out_valid, not the result fields.
// While the receiver stalls, the held result blocks the input; in_ready
// is high whenever the output register is empty or being drained.
`default_nettype none
module sorted_priority_queue (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic                       in_valid,
  output logic                            in_ready,
  input  wire logic [1:0]                 operation,
  input  wire logic [spq_pkg::ID_W-1:0]   task_id,
  input  wire logic [spq_pkg::PRI_W-1:0]  priority_req,
  output logic                            out_valid,
  input  wire logic                       out_ready,
  output logic [1:0]                      status,
  output logic [spq_pkg::ID_W-1:0]        removed_id,
  output logic [spq_pkg::PRI_W-1:0]       removed_priority,
  output logic [spq_pkg::CNT_W-1:0]       entry_count
);
  import spq_pkg::*;

  localparam entry_t EMPTY_ENTRY = '{valid: 1'b0, id: '0, pri: '0};

  logic                in_fire;
  op_t                 op;
  cmd_t                cmd;
  logic [CNT_W-1:0]    count;
  logic [CNT_W-1:0]    count_next;
  entry_t              cells [CAPACITY];
  logic [CAPACITY-1:0] ge_vec;
  logic [CAPACITY-1:0] match_vec;
  logic [CAPACITY-1:0] hit_upto;
  logic [CAPACITY-1:0] first_hit;
  logic [CAPACITY-1:0] shift_vec;
  logic [CAPACITY-1:0] valid_vec;
  status_t             res_status;
  logic [ID_W-1:0]     res_id;
  logic [PRI_W-1:0]    res_pri;
  logic [ID_W-1:0]     del_id;
  logic [PRI_W-1:0]    del_pri;
  logic                is_empty;
  logic                is_full;

  assign in_ready = !out_valid || out_ready;
  assign in_fire  = in_valid && in_ready;
  assign op       = op_t'(operation);
  assign is_empty = (count == '0);
  assign is_full  = (count == CNT_W'(CAPACITY));

  // Inclusive prefix OR: cell i has a match at or before it.
  always_comb begin
    hit_upto = match_vec;
    for (int s = 1; s < CAPACITY; s = s * 2) begin
      hit_upto = hit_upto | (hit_upto << s);
    end
    first_hit = match_vec & ~(hit_upto << 1);
  end

  always_comb begin
    del_id  = '0;
    del_pri = '0;
    for (int i = 0; i < CAPACITY; i++) begin
      del_id  = del_id  | ({ID_W{first_hit[i]}} & cells[i].id);
      del_pri = del_pri | ({PRI_W{first_hit[i]}} & cells[i].pri);
    end
  end

  always_comb begin
    cmd        = '{act: ACT_HOLD, id: task_id, pri: priority_req};
    shift_vec  = '0;
    count_next = count;
    res_status = ST_OK;
    res_id     = '0;
    res_pri    = '0;
    unique case (op)
      OP_INSERT: begin
        if (is_full) begin
          res_status = ST_FULL;
        end else begin
          cmd.act    = ACT_INSERT;
          count_next = count + 1'b1;
        end
      end
      OP_POP: begin
        if (is_empty) begin
          res_status = ST_EMPTY;
        end else begin
          cmd.act    = ACT_REMOVE;
          shift_vec  = '1;
          count_next = count - 1'b1;
          res_id     = cells[0].id;
          res_pri    = cells[0].pri;
        end
      end
      OP_DELETE: begin
        if (is_empty) begin
          res_status = ST_EMPTY;
        end else if (!hit_upto[CAPACITY-1]) begin
          res_status = ST_NOT_FOUND;
        end else begin
          cmd.act    = ACT_REMOVE;
          shift_vec  = hit_upto;
          count_next = count - 1'b1;
          res_id     = del_id;
          res_pri    = del_pri;
        end
      end
      default: begin
        res_status = ST_OK;
      end
    endcase
    // Leave the chain untouched unless an item transfers this cycle.
    if (!in_fire) begin
      cmd.act    = ACT_HOLD;
      count_next = count;
    end
  end

  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    entry_t left_e;
    entry_t right_e;
    logic   left_g;

    if (i == 0) begin : g_head
      assign left_e = EMPTY_ENTRY;
      assign left_g = 1'b1;
    end else begin : g_mid
      assign left_e = cells[i-1];
      assign left_g = ge_vec[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_e = EMPTY_ENTRY;
    end else begin : g_body
      assign right_e = cells[i+1];
    end

    spq_cell u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .left_entry  (left_e),
      .right_entry (right_e),
      .left_ge     (left_g),
      .shift       (shift_vec[i]),
      .entry       (cells[i]),
      .ge          (ge_vec[i]),
      .match       (match_vec[i])
    );

    assign valid_vec[i] = cells[i].valid;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      count <= count_next;
      if (in_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      status           <= res_status;
      removed_id       <= res_id;
      removed_priority <= res_pri;
      entry_count      <= count_next;
    end
  end

  // Valid cells form a packed prefix whose size is the count.
  a_count_matches_cells: assert property (@(posedge clk) disable iff (rst)
    $countones(valid_vec) == count)
    else $error("valid cells disagree with entry count");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(CAPACITY))
    else $error("entry count above capacity");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && (status == ST_FULL) |-> entry_count == CNT_W'(CAPACITY))
    else $error("full status reported below capacity");

  a_pop_decrements: assert property (@(posedge clk) disable iff (rst)
    in_fire && (op == OP_POP) && !is_empty |=> count == $past(count) - 1'b1)
    else $error("pop did not remove one entry");

  a_order: assert property (@(posedge clk) disable iff (rst)
    valid_vec[1] |-> cells[0].pri >= cells[1].pri)
    else $error("head entry out of priority order");

endmodule
`default_nettype wire

// ----- rtl/core/spq_cell.sv -----
// One slot of the sorted chain: holds an entry, trades it with its neighbors.
`default_nettype none
module spq_cell (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire spq_pkg::cmd_t   cmd,
  input  wire spq_pkg::entry_t left_entry,
  input  wire spq_pkg::entry_t right_entry,
  input  wire logic            left_ge,
  input  wire logic            shift,
  output spq_pkg::entry_t      entry,
  output logic                 ge,
  output logic                 match
);
  import spq_pkg::*;

  logic             valid;
  logic [ID_W-1:0]  id;
  logic [PRI_W-1:0] pri;
  entry_t           entry_next;

  assign entry = '{valid: valid, id: id, pri: pri};
  // Entry stays ahead of a new insert: equal or higher priority.
  assign ge    = valid && (pri >= cmd.pri);
  assign match = valid && (id == cmd.id);

  always_comb begin
    entry_next = entry;
    unique case (cmd.act)
      ACT_INSERT: begin
        if (ge) begin
          entry_next = entry;
        end else if (left_ge) begin
          entry_next = '{valid: 1'b1, id: cmd.id, pri: cmd.pri};
        end else begin
          entry_next = left_entry;
        end
      end
      ACT_REMOVE: begin
        if (shift) begin
          entry_next = right_entry;
        end
      end
      default: begin
        entry_next = entry;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= entry_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    id  <= entry_next.id;
    pri <= entry_next.pri;
  end

endmodule
`default_nettype wire

// ----- sim/tb_sorted_priority_queue.sv -----
// Self-checking testbench for the sorted priority queue: directed table, then random traffic.
`timescale 1ns / 1ps

module tb_sorted_priority_queue;
  import spq_pkg::*;

  localparam int RANDOM_ITEMS = 1700;
  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRILL_ROWS   = 27;
  localparam int IDX_W        = $clog2(CAPACITY);

  typedef struct packed {
    logic [1:0]       st;
    logic [ID_W-1:0]  rid;
    logic [PRI_W-1:0] rpri;
    logic [CNT_W-1:0] count;
  } outcome_t;

  typedef struct packed {
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    bit               typed;
    outcome_t         want;
  } drill_row_t;

  logic             clk;
  logic             rst;
  logic             in_valid;
  logic             in_ready;
  logic [1:0]       operation;
  logic [ID_W-1:0]  task_id;
  logic [PRI_W-1:0] priority_req;
  logic             out_valid;
  logic             out_ready = 1'b0;
  logic [1:0]       status;
  logic [ID_W-1:0]  removed_id;
  logic [PRI_W-1:0] removed_priority;
  logic [CNT_W-1:0] entry_count;

  // Shadow copy of the queue contents, head at index 0.
  logic [ID_W-1:0]  held_id  [CAPACITY];
  logic [PRI_W-1:0] held_pri [CAPACITY];
  int               held;

  outcome_t pending_results [$];
  int       mismatch_count;
  int       cycle_count;
  int       burst_left;

  drill_row_t drills [DRILL_ROWS] = '{
    '{OP_POP,    16'h0000, 8'h00, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 5'd0}},
    '{OP_DELETE, 16'h0000, 8'h00, 1'b1, '{ST_EMPTY, 16'h0, 8'h0, 5'd0}},
    '{OP_NONE,   16'h0000, 8'h00, 1'b1, '{ST_OK, 16'h0, 8'h0, 5'd0}},
    '{OP_INSERT, 16'hffff, 8'hff, 1'b1, '{ST_OK, 16'h0, 8'h0, 5'd1}},
    '{OP_INSERT, 16'h0000, 8'h00, 1'b1, '{ST_OK, 16'h0, 8'h0, 5'd2}},
    '{OP_INSERT, 16'h1234, 8'hff, 1'b0, '0},
    '{OP_DELETE, 16'h5555, 8'h00, 1'b1, '{ST_NOT_FOUND, 16'h0, 8'h0, 5'd3}},
    '{OP_DELETE, 16'h0000, 8'h00, 1'b0, '0},
    '{OP_POP,    16'h0000, 8'h00, 1'b0, '0},
    '{OP_INSERT, 16'h0100, 8'hff, 1'b0, '0},
    '{OP_INSERT, 16'h0101, 8'h00, 1'b0, '0},
    '{OP_INSERT, 16'h0102, 8'h80, 1'b0, '0},
    '{OP_INSERT, 16'h0103, 8'h80, 1'b0, '0},
    '{OP_INSERT, 16'h0104, 8'h7f, 1'b0, '0},
    '{OP_INSERT, 16'h0105, 8'h01, 1'b0, '0},
    '{OP_INSERT, 16'h0106, 8'hfe, 1'b0, '0},
    '{OP_INSERT, 16'h0107, 8'h80, 1'b0, '0},
    '{OP_INSERT, 16'h0108, 8'h00, 1'b0, '0},
    '{OP_INSERT, 16'h0109, 8'h40, 1'b0, '0},
    '{OP_INSERT, 16'h010a, 8'hc0, 1'b0, '0},
    '{OP_INSERT, 16'h010b, 8'h80, 1'b0, '0},
    '{OP_INSERT, 16'h010c, 8'h20, 1'b0, '0},
    '{OP_INSERT, 16'h010d, 8'hff, 1'b0, '0},
    '{OP_INSERT, 16'h010e, 8'h10, 1'b0, '0},
    '{OP_INSERT, 16'hbeef, 8'h55, 1'b1, '{ST_FULL, 16'h0, 8'h0, 5'd16}},
    '{OP_NONE,   16'hffff, 8'hff, 1'b0, '0},
    '{OP_POP,    16'h0000, 8'h00, 1'b0, '0}
  };

  sorted_priority_queue dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .operation        (operation),
    .task_id          (task_id),
    .priority_req     (priority_req),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .status           (status),
    .removed_id       (removed_id),
    .removed_priority (removed_priority),
    .entry_count      (entry_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Close the gap left by the entry at pos.
  function automatic void drop_entry(int pos);
    for (int i = pos; i + 1 < held; i++) begin
      held_id[i]  = held_id[i + 1];
      held_pri[i] = held_pri[i + 1];
    end
    held--;
  endfunction

  function automatic outcome_t apply_request(op_t op, logic [ID_W-1:0] id,
                                             logic [PRI_W-1:0] pri);
    outcome_t r;
    int       pos;
    r   = '0;
    r.st = ST_OK;
    pos = 0;
    case (op)
      OP_INSERT: begin
        if (held >= CAPACITY) begin
          r.st = ST_FULL;
        end else begin
          // Land behind every entry of equal or higher priority.
          while (pos < held && held_pri[pos] >= pri) pos++;
          for (int i = held; i > pos; i--) begin
            held_id[i]  = held_id[i - 1];
            held_pri[i] = held_pri[i - 1];
          end
          held_id[pos]  = id;
          held_pri[pos] = pri;
          held++;
        end
      end
      OP_POP: begin
        if (held == 0) begin
          r.st = ST_EMPTY;
        end else begin
          r.rid  = held_id[0];
          r.rpri = held_pri[0];
          drop_entry(0);
        end
      end
      OP_DELETE: begin
        if (held == 0) begin
          r.st = ST_EMPTY;
        end else begin
          while (pos < held && held_id[pos] != id) pos++;
          if (pos >= held) begin
            r.st = ST_NOT_FOUND;
          end else begin
            r.rid  = held_id[pos];
            r.rpri = held_pri[pos];
            drop_entry(pos);
          end
        end
      end
      default: ;
    endcase
    r.count = CNT_W'(held);
    return r;
  endfunction

  // Offer one request (after an idle gap when a burst is used up), wait for its transfer, then log the expected result.
  task automatic send_item(input op_t op, input logic [ID_W-1:0] id,
                           input logic [PRI_W-1:0] pri, input bit typed,
                           input outcome_t want);
    outcome_t model;
    if (burst_left == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 250)
                                               : $urandom_range(1, 30);
    end
    in_valid     <= 1'b1;
    operation    <= op;
    task_id      <= id;
    priority_req <= pri;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    burst_left--;
    model = apply_request(op, id, pri);
    pending_results.push_back(typed ? want : model);
  endtask

  // Hold off the sender until every outstanding result has drained.
  task automatic drain_pause();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  initial begin
    op_t              op;
    logic [ID_W-1:0]  id;
    logic [PRI_W-1:0] pri;
    int               insert_pct;
    int               pick;
    rst            = 1'b1;
    in_valid       = 1'b0;
    operation      = OP_NONE;
    task_id        = '0;
    priority_req   = '0;
    held           = 0;
    mismatch_count = 0;
    burst_left     = 0;
    insert_pct     = 50;
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    for (int k = 0; k < DRILL_ROWS; k++) begin
      send_item(drills[k].op, drills[k].id, drills[k].pri, drills[k].typed, drills[k].want);
    end
    drain_pause();

    for (int n = 0; n < RANDOM_ITEMS; n++) begin
      // Swing the insert mix so the queue sweeps between empty and full.
      if (n % 120 == 0) begin
        case ($urandom_range(0, 3))
          0: insert_pct = 85;
          1: insert_pct = 50;
          2: insert_pct = 20;
          default: insert_pct = 60;
        endcase
      end
      if (n == RANDOM_ITEMS / 2) drain_pause();

      pick = $urandom_range(0, 9);
      if (pick < 3) pri = PRI_W'($urandom_range(0, 3));
      else if (pick == 3) pri = 8'hff;
      else if (pick == 4) pri = PRI_W'($urandom_range(252, 255));
      else pri = PRI_W'($urandom_range(0, 255));

      pick = $urandom_range(0, 99);
      if (pick < 2) begin
        op = OP_NONE;
        id = ID_W'($urandom_range(0, 65535));
      end else if (pick < 2 + insert_pct * 98 / 100) begin
        op = OP_INSERT;
        // Reuse a small id pool now and then so deletes see duplicates.
        id = ($urandom_range(0, 9) < 3) ? ID_W'($urandom_range(0, 7))
                                        : ID_W'($urandom_range(0, 65535));
      end else if ($urandom_range(0, 1) == 0) begin
        op = OP_POP;
        id = ID_W'($urandom_range(0, 65535));
      end else begin
        op   = OP_DELETE;
        pick = $urandom_range(0, 9);
        if (held > 0 && pick < 7) id = held_id[IDX_W'($urandom_range(0, held - 1))];
        else if (pick < 8) id = ID_W'($urandom_range(0, 7));
        else id = ID_W'($urandom_range(0, 65535));
      end
      send_item(op, id, pri, 1'b0, '0);
    end

    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (5) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("[sorted_priority_queue] OK");
    end else begin
      $display("[sorted_priority_queue] ERROR");
    end
    $finish;
  end

  // Receiver stall pattern, reshuffled at random among five modes.
  int stall_mode = 0;
  always @(posedge clk) begin
    if (cycle_count % 97 == 0) stall_mode <= $urandom_range(0, 4);
    case (stall_mode)
      0: out_ready <= 1'b1;
      1: out_ready <= 1'($urandom_range(0, 1));
      2: out_ready <= (cycle_count % 5 == 0);
      3: out_ready <= ($urandom_range(0, 7) != 0);
      default: out_ready <= (cycle_count % 15 >= 12);
    endcase
  end

  always @(posedge clk) begin
    outcome_t want;
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("unexpected transfer: status=%0d removed_id=%h count=%0d",
               status, removed_id, entry_count);
        mismatch_count++;
      end else begin
        want = pending_results.pop_front();
        if (status !== want.st) begin
          $error("status: expected %0d, got %0d", want.st, status);
          mismatch_count++;
        end
        if (removed_id !== want.rid) begin
          $error("removed_id: expected %h, got %h", want.rid, removed_id);
          mismatch_count++;
        end
        if (removed_priority !== want.rpri) begin
          $error("removed_priority: expected %h, got %h", want.rpri, removed_priority);
          mismatch_count++;
        end
        if (entry_count !== want.count) begin
          $error("entry_count: expected %0d, got %0d", want.count, entry_count);
          mismatch_count++;
        end
      end
    end
  end

  initial cycle_count = 0;
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("[sorted_priority_queue] ERROR");
      $finish;
    end
  end

endmodule
